FILE: hw/rtl/uv_sphere_triangle_indexer_unit_assert.svh
// Assertion macros shared by the checker of the UV-sphere triangle indexer.
// Depends on nothing; included by usti_checker.sv.
`ifndef UV_SPHERE_TRIANGLE_INDEXER_UNIT_ASSERT_SVH
`define UV_SPHERE_TRIANGLE_INDEXER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define USTI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define USTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define USTI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/usti_pkg.sv
// Package for the UV-sphere triangle indexer: widths, band codes and the
// sideband record that travels beside the divider. Depends on nothing.
`default_nettype none

package usti_pkg;

   localparam int MAX_SLICES = 256;
   localparam int MAX_STACKS = 256;
   localparam int MIN_SLICES = 3;
   localparam int MIN_STACKS = 2;

   localparam int TRI_W    = 17;
   localparam int CORNER_W = 16;
   localparam int CFG_W    = 9;
   localparam int PROD_W   = 17;
   localparam int QUAD_W   = 16;

   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = 2;
   localparam int QUO_W      = DIV_STAGES * DIV_STEPS;
   localparam int REM_W      = 8;

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic REG_SLICE_COUNT = 1'b0;
   localparam logic REG_STACK_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] SLICE_RESET = 9'd16;
   localparam logic [CFG_W-1:0] STACK_RESET = 9'd8;

   typedef enum logic [1:0] {
      BAND_SOUTH,
      BAND_MIDDLE,
      BAND_NORTH,
      BAND_ERROR
   } band_type;

   typedef struct packed {
      band_type                band;
      logic                    half;
      logic [CFG_W-1:0]        n_low;
      logic [CFG_W-1:0]        k;
      logic [CFG_W-1:0]        s;
      logic [CORNER_W-1:0]     pole;
      logic [CORNER_W-1:0]     ring;
   } side_type;

endpackage

`default_nettype wire

FILE: hw/rtl/usti_if.sv
// Valid/ready channel interfaces for the triangle number requests and the
// corner index responses. Depends on usti_pkg.
`default_nettype none

interface usti_req_if
   import usti_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [TRI_W-1:0] tri_number;

   modport source (output valid, output tri_number, input ready);
   modport sink (input valid, input tri_number, output ready);
endinterface

interface usti_rsp_if
   import usti_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CORNER_W-1:0] corner_a;
   logic [CORNER_W-1:0] corner_b;
   logic [CORNER_W-1:0] corner_c;
   logic                range_error;

   modport source (output valid, output corner_a, output corner_b, output corner_c,
                   output range_error, input ready);
   modport sink (input valid, input corner_a, input corner_b, input corner_c,
                 input range_error, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/uv_sphere_triangle_indexer_unit.sv
// UV-sphere triangle indexer: maps a triangle number to its three vertex indices.
// Depends on usti_pkg, usti_if and usti_div.
//
// The block accepts one triangle number per clock when the response side is not
// stalled and passes it, in order, through an input register, a slices-by-stacks
// multiplier, four divider stages that split the quad number into stack and slice,
// a ring-base multiplier and the output register. Stalls on the response side
// propagate back stage by stage, so empty stages still fill while the output waits.
`default_nettype none

module uv_sphere_triangle_indexer_unit
   import usti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   usti_req_if.sink               req_chan,
   usti_rsp_if.source             rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [CFG_W-1:0] slice_ff, slice_in;
   logic [CFG_W-1:0] stack_ff, stack_in;
   logic             csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      slice_in = slice_ff;
      stack_in = stack_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_SLICE_COUNT: slice_in = csr_pwdata[CFG_W-1:0];
            REG_STACK_COUNT: stack_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SLICE_COUNT: csr_prdata = {{(DATA_W - CFG_W){1'b0}}, slice_ff};
         REG_STACK_COUNT: csr_prdata = {{(DATA_W - CFG_W){1'b0}}, stack_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= SLICE_RESET;
         stack_ff <= STACK_RESET;
      end else begin
         slice_ff <= slice_in;
         stack_ff <= stack_in;
      end
   end

   logic adv1, adv2, adv3, adv4;
   logic div_in_ready, div_out_valid;

   // Stage 1: input register with clamped mesh dimensions.
   logic             v1_ff;
   logic [TRI_W-1:0] n1_ff;
   logic [CFG_W-1:0] s1_ff, s1_in;
   logic [CFG_W-1:0] t1_ff, t1_in;

   always_comb begin
      if (slice_ff < CFG_W'(MIN_SLICES)) begin
         s1_in = CFG_W'(MIN_SLICES);
      end else if (slice_ff > CFG_W'(MAX_SLICES)) begin
         s1_in = CFG_W'(MAX_SLICES);
      end else begin
         s1_in = slice_ff;
      end
      if (stack_ff < CFG_W'(MIN_STACKS)) begin
         t1_in = CFG_W'(MIN_STACKS);
      end else if (stack_ff > CFG_W'(MAX_STACKS)) begin
         t1_in = CFG_W'(MAX_STACKS);
      end else begin
         t1_in = stack_ff;
      end
   end

   // Stage 2: ring product s * (t - 1).
   logic              v2_ff;
   logic [TRI_W-1:0]  n2_ff;
   logic [CFG_W-1:0]  s2_ff;
   logic [PROD_W-1:0] prod2_ff, prod2_in;

   assign prod2_in = {{(PROD_W - CFG_W){1'b0}}, s1_ff}
                   * {{(PROD_W - CFG_W){1'b0}}, t1_ff - CFG_W'(1)};

   // Band classification in front of the divider.
   logic [PROD_W:0]     total, north_lim, n_ext, s_ext, diff, k_full;
   logic [QUAD_W-1:0]   quad;
   side_type            side2;

   always_comb begin
      total     = {prod2_ff, 1'b0};
      n_ext     = {{(PROD_W + 1 - TRI_W){1'b0}}, n2_ff};
      s_ext     = {{(PROD_W + 1 - CFG_W){1'b0}}, s2_ff};
      north_lim = total - s_ext;
      diff      = n_ext - s_ext;
      k_full    = n_ext - north_lim;
      quad      = diff[QUAD_W:1];
      if (n_ext >= total) begin
         side2.band = BAND_ERROR;
      end else if (n_ext < s_ext) begin
         side2.band = BAND_SOUTH;
      end else if (n_ext < north_lim) begin
         side2.band = BAND_MIDDLE;
      end else begin
         side2.band = BAND_NORTH;
      end
      side2.half  = diff[0];
      side2.n_low = n2_ff[CFG_W-1:0];
      side2.k     = k_full[CFG_W-1:0];
      side2.s     = s2_ff;
      side2.pole  = prod2_ff[CORNER_W-1:0] + CORNER_W'(1);
      side2.ring  = side2.pole - {{(CORNER_W - CFG_W){1'b0}}, s2_ff};
   end

   logic [QUO_W-1:0] div_quot;
   logic [REM_W-1:0] div_rem;
   side_type         div_side;

   usti_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v2_ff),
      .in_ready    (div_in_ready),
      .in_dividend (quad),
      .in_divisor  (s2_ff),
      .in_side     (side2),
      .out_valid   (div_out_valid),
      .out_ready   (adv3),
      .out_quot    (div_quot),
      .out_rem     (div_rem),
      .out_side    (div_side)
   );

   // Stage 3: ring base 1 + stack * s and the wrapped next slice.
   logic                v3_ff;
   logic [CORNER_W-1:0] down3_ff, down3_in;
   logic [REM_W-1:0]    slice3_ff;
   logic [CFG_W-1:0]    next3_ff, next3_in;
   side_type            side3_ff;
   logic [PROD_W-1:0]   base_prod;
   logic [CFG_W-1:0]    slice_inc;

   always_comb begin
      base_prod = {{(PROD_W - QUO_W){1'b0}}, div_quot}
                * {{(PROD_W - CFG_W){1'b0}}, div_side.s};
      down3_in  = base_prod[CORNER_W-1:0] + CORNER_W'(1);
      slice_inc = {{(CFG_W - REM_W){1'b0}}, div_rem} + CFG_W'(1);
      next3_in  = (slice_inc == div_side.s) ? '0 : slice_inc;
   end

   // Stage 4: corner selection into the output register.
   logic                v4_ff;
   logic [CORNER_W-1:0] a4_ff, a4_in;
   logic [CORNER_W-1:0] b4_ff, b4_in;
   logic [CORNER_W-1:0] c4_ff, c4_in;
   logic                err4_ff, err4_in;

   always_comb begin
      logic [CORNER_W-1:0] up, s16, next16, slice16, n16, k16;
      logic [CFG_W-1:0]    n_inc, k_inc;
      s16     = {{(CORNER_W - CFG_W){1'b0}}, side3_ff.s};
      up      = down3_ff + s16;
      next16  = {{(CORNER_W - CFG_W){1'b0}}, next3_ff};
      slice16 = {{(CORNER_W - REM_W){1'b0}}, slice3_ff};
      n16     = {{(CORNER_W - CFG_W){1'b0}}, side3_ff.n_low};
      k16     = {{(CORNER_W - CFG_W){1'b0}}, side3_ff.k};
      n_inc   = side3_ff.n_low + CFG_W'(1);
      k_inc   = side3_ff.k + CFG_W'(1);
      a4_in   = '0;
      b4_in   = '0;
      c4_in   = '0;
      err4_in = 1'b0;
      case (side3_ff.band)
         BAND_SOUTH: begin
            b4_in = (n_inc == side3_ff.s) ? CORNER_W'(1) : n16 + CORNER_W'(2);
            c4_in = n16 + CORNER_W'(1);
         end
         BAND_MIDDLE: begin
            a4_in = down3_ff + slice16;
            if (!side3_ff.half) begin
               b4_in = down3_ff + next16;
               c4_in = up + next16;
            end else begin
               b4_in = up + next16;
               c4_in = up + slice16;
            end
         end
         BAND_NORTH: begin
            a4_in = side3_ff.pole;
            b4_in = side3_ff.ring + k16;
            c4_in = (k_inc == side3_ff.s) ? side3_ff.ring
                  : side3_ff.ring + {{(CORNER_W - CFG_W){1'b0}}, k_inc};
         end
         default: begin
            err4_in = 1'b1;
         end
      endcase
   end

   assign adv4 = !v4_ff || rsp_chan.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || div_in_ready;
   assign adv1 = !v1_ff || adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_chan.valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= div_out_valid;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         n1_ff <= req_chan.tri_number;
         s1_ff <= s1_in;
         t1_ff <= t1_in;
      end
      if (adv2) begin
         n2_ff    <= n1_ff;
         s2_ff    <= s1_ff;
         prod2_ff <= prod2_in;
      end
      if (adv3) begin
         down3_ff  <= down3_in;
         slice3_ff <= div_rem;
         next3_ff  <= next3_in;
         side3_ff  <= div_side;
      end
      if (adv4) begin
         a4_ff   <= a4_in;
         b4_ff   <= b4_in;
         c4_ff   <= c4_in;
         err4_ff <= err4_in;
      end
   end

   assign req_chan.ready       = adv1;
   assign rsp_chan.valid       = v4_ff;
   assign rsp_chan.corner_a    = a4_ff;
   assign rsp_chan.corner_b    = b4_ff;
   assign rsp_chan.corner_c    = c4_ff;
   assign rsp_chan.range_error = err4_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/usti_div.sv
// Pipelined restoring divider, two quotient bits per stage, with a sideband
// record carried alongside. Depends on usti_pkg.
`default_nettype none

module usti_div
   import usti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [QUAD_W-1:0] in_dividend,
   input  wire logic [CFG_W-1:0]  in_divisor,
   input  wire side_type          in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [QUO_W-1:0]       out_quot,
   output logic [REM_W-1:0]       out_rem,
   output side_type               out_side
);

   logic                valid_ff [DIV_STAGES];
   logic [QUAD_W-1:0]   rem_ff   [DIV_STAGES];
   logic [QUO_W-1:0]    quot_ff  [DIV_STAGES];
   logic [CFG_W-1:0]    dsr_ff   [DIV_STAGES];
   side_type            side_ff  [DIV_STAGES];

   logic                adv      [DIV_STAGES];
   logic                valid_in [DIV_STAGES];
   logic [QUAD_W-1:0]   rem_in   [DIV_STAGES];
   logic [QUO_W-1:0]    quot_in  [DIV_STAGES];
   logic [CFG_W-1:0]    dsr_in   [DIV_STAGES];
   side_type            side_in  [DIV_STAGES];

   always_comb begin
      for (int j = DIV_STAGES - 1; j >= 0; j--) begin
         if (j == DIV_STAGES - 1) begin
            adv[j] = !valid_ff[j] || out_ready;
         end else begin
            adv[j] = !valid_ff[j] || adv[j+1];
         end
      end
   end

   always_comb begin
      logic [QUAD_W:0]   shifted;
      logic [QUAD_W-1:0] rem;
      logic [QUO_W-1:0]  quot;
      logic [CFG_W-1:0]  dsr;
      int                bit_pos;
      shifted = '0;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            valid_in[j] = in_valid;
            rem         = in_dividend;
            quot        = '0;
            dsr         = in_divisor;
            side_in[j]  = in_side;
         end else begin
            valid_in[j] = valid_ff[j-1];
            rem         = rem_ff[j-1];
            quot        = quot_ff[j-1];
            dsr         = dsr_ff[j-1];
            side_in[j]  = side_ff[j-1];
         end
         for (int b = 0; b < DIV_STEPS; b++) begin
            bit_pos = QUO_W - 1 - j * DIV_STEPS - b;
            shifted = (QUAD_W + 1)'({{(QUAD_W + 1 - CFG_W){1'b0}}, dsr} << bit_pos);
            if ({1'b0, rem} >= shifted) begin
               rem           = rem - shifted[QUAD_W-1:0];
               quot[bit_pos] = 1'b1;
            end
         end
         rem_in[j]  = rem;
         quot_in[j] = quot;
         dsr_in[j]  = dsr;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            valid_ff[j] <= valid_in[j];
         end
         if (adv[j]) begin
            rem_ff[j]  <= rem_in[j];
            quot_ff[j] <= quot_in[j];
            dsr_ff[j]  <= dsr_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quot  = quot_ff[DIV_STAGES-1];
   assign out_rem   = rem_ff[DIV_STAGES-1][REM_W-1:0];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/usti_checker.sv
// Port-level assertions for the UV-sphere triangle indexer and the bind that
// attaches them. Depends on usti_pkg and uv_sphere_triangle_indexer_unit_assert.svh.
`default_nettype none

`include "uv_sphere_triangle_indexer_unit_assert.svh"

module usti_checker
   import usti_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [CORNER_W-1:0] corner_a,
   input wire logic [CORNER_W-1:0] corner_b,
   input wire logic [CORNER_W-1:0] corner_c,
   input wire logic                range_error
);

   `USTI_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "response valid after reset")

   `USTI_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(corner_a) && $stable(corner_b) && $stable(corner_c) && $stable(range_error), "stalled response transaction changed")

   `USTI_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_valid && range_error, corner_a == '0 && corner_b == '0 && corner_c == '0, "range error with nonzero corners")

   `USTI_ASSERT_IMPLY(a_south_pole, clock, reset, rsp_valid && !range_error && corner_a == '0, corner_b != '0 && corner_c != '0, "south fan triangle reuses the pole")

endmodule

bind uv_sphere_triangle_indexer_unit usti_checker u_usti_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .corner_a    (rsp_chan.corner_a),
   .corner_b    (rsp_chan.corner_b),
   .corner_c    (rsp_chan.corner_c),
   .range_error (rsp_chan.range_error)
);

`default_nettype wire
